// ===== design/orsp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orsp_pkg
// Types and constants shared by the object record stream parser.
// ---------------------------------------------------------------------------
package orsp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned HALF_W = 6;
	localparam int unsigned WORD_W = 12;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned COUNT_W = 9;

	localparam logic [BYTE_W-1:0] MAGIC_0 = 8'h4F; // 'O'
	localparam logic [BYTE_W-1:0] MAGIC_1 = 8'h42; // 'B'
	localparam logic [BYTE_W-1:0] MAGIC_2 = 8'h4A; // 'J'
	localparam logic [BYTE_W-1:0] MAGIC_3 = 8'h38; // '8'

	typedef enum logic [11:0] {
		PH_MAGIC0 = 12'b0000_0000_0001,
		PH_MAGIC1 = 12'b0000_0000_0010,
		PH_MAGIC2 = 12'b0000_0000_0100,
		PH_MAGIC3 = 12'b0000_0000_1000,
		PH_EP_HI  = 12'b0000_0001_0000,
		PH_EP_LO  = 12'b0000_0010_0000,
		PH_LEN    = 12'b0000_0100_0000,
		PH_ADR_HI = 12'b0000_1000_0000,
		PH_ADR_LO = 12'b0001_0000_0000,
		PH_DAT_HI = 12'b0010_0000_0000,
		PH_DAT_LO = 12'b0100_0000_0000,
		PH_WAIT   = 12'b1000_0000_0000
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_EP    = 3'd0,
		KIND_DATA  = 3'd1,
		KIND_DONE  = 3'd2,
		KIND_MAGIC = 3'd3,
		KIND_SHORT = 3'd4
	} kind_t;

	typedef struct packed {
		phase_t                     phase;
		logic signed [COUNT_W-1:0]  bytes_left;
		logic [WORD_W-1:0]          current_address;
		logic [HALF_W-1:0]          upper_half;
		logic                       stray_seen;
		logic                       magic_mismatch;
	} parse_state_t;

	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [WORD_W-1:0]  address;
		logic [WORD_W-1:0]  value;
		logic               stray;
	} parse_result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:           PH_MAGIC0,
		bytes_left:      '0,
		current_address: '0,
		upper_half:      '0,
		stray_seen:      1'b0,
		magic_mismatch:  1'b0
	};

endpackage

// ===== design/orsp_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orsp_step
// Next-state and result logic for one stream item of the record parser.
// ---------------------------------------------------------------------------
module orsp_step
	import orsp_pkg::*;
(
	input  parse_state_t         cur,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 end_of_input,
	output parse_state_t         nxt,
	output parse_result_t        res
);

	logic [HALF_W-1:0]          half;
	logic                       byte_stray;
	logic                       stray_now;
	logic [WORD_W-1:0]          word;
	logic signed [COUNT_W-1:0]  left_after;
	logic                       more_words;
	logic [BYTE_W-1:0]          magic_exp;
	logic                       mismatch;

	assign half       = data_byte[HALF_W-1:0];
	assign byte_stray = |data_byte[BYTE_W-1:HALF_W];
	assign stray_now  = cur.stray_seen | byte_stray;
	assign word       = {cur.upper_half, half};
	assign left_after = cur.bytes_left - COUNT_W'(2);
	assign more_words = !left_after[COUNT_W-1] && (|left_after);

	always_comb begin
		unique case (cur.phase)
			PH_MAGIC0: magic_exp = MAGIC_0;
			PH_MAGIC1: magic_exp = MAGIC_1;
			PH_MAGIC2: magic_exp = MAGIC_2;
			default:   magic_exp = MAGIC_3;
		endcase
	end

	assign mismatch = cur.magic_mismatch | (data_byte != magic_exp);

	always_comb begin
		nxt         = cur;
		res.valid   = 1'b0;
		res.kind    = KIND_EP;
		res.address = '0;
		res.value   = '0;
		res.stray   = cur.stray_seen;
		if (end_of_input) begin
			nxt = STATE_RESET;
			unique case (cur.phase)
				PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3: begin
					res.valid = 1'b1;
					res.kind  = KIND_MAGIC;
				end
				PH_LEN: begin
					res.valid = 1'b1;
					res.kind  = KIND_DONE;
				end
				PH_EP_HI, PH_EP_LO, PH_ADR_HI, PH_ADR_LO, PH_DAT_HI, PH_DAT_LO: begin
					res.valid = 1'b1;
					res.kind  = KIND_SHORT;
				end
				default: ;
			endcase
		end else begin
			unique case (cur.phase)
				PH_MAGIC0: begin
					nxt.magic_mismatch = mismatch;
					nxt.phase          = PH_MAGIC1;
				end
				PH_MAGIC1: begin
					nxt.magic_mismatch = mismatch;
					nxt.phase          = PH_MAGIC2;
				end
				PH_MAGIC2: begin
					nxt.magic_mismatch = mismatch;
					nxt.phase          = PH_MAGIC3;
				end
				PH_MAGIC3: begin
					nxt.magic_mismatch = mismatch;
					if (mismatch) begin
						nxt.phase      = PH_WAIT;
						nxt.stray_seen = 1'b0;
						res.valid      = 1'b1;
						res.kind       = KIND_MAGIC;
					end else begin
						nxt.phase = PH_EP_HI;
					end
				end
				PH_EP_HI, PH_ADR_HI, PH_DAT_HI: begin
					nxt.upper_half = half;
					nxt.stray_seen = stray_now;
					nxt.phase      = (cur.phase == PH_EP_HI)  ? PH_EP_LO :
					                 (cur.phase == PH_ADR_HI) ? PH_ADR_LO : PH_DAT_LO;
				end
				PH_EP_LO: begin
					nxt.stray_seen = 1'b0;
					nxt.phase      = PH_LEN;
					res.valid      = 1'b1;
					res.kind       = KIND_EP;
					res.value      = word;
					res.stray      = stray_now;
				end
				PH_LEN: begin
					// length n leaves n - 1 counted bytes, signed
					nxt.bytes_left = $signed({1'b0, data_byte}) - COUNT_W'(1);
					nxt.phase      = PH_ADR_HI;
				end
				PH_ADR_LO: begin
					nxt.current_address = word;
					nxt.bytes_left      = left_after;
					nxt.stray_seen      = stray_now;
					nxt.phase           = more_words ? PH_DAT_HI : PH_LEN;
				end
				PH_DAT_LO: begin
					nxt.current_address = cur.current_address + WORD_W'(1);
					nxt.bytes_left      = left_after;
					nxt.stray_seen      = 1'b0;
					nxt.phase           = more_words ? PH_DAT_HI : PH_LEN;
					res.valid           = 1'b1;
					res.kind            = KIND_DATA;
					res.address         = cur.current_address;
					res.value           = word;
					res.stray           = stray_now;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== design/object_record_stream_parser_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// object_record_stream_parser_unit
// Parses a magic-tagged object stream into entry point, data word and status results.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) moves one item per cycle: a byte, or an
// end mark when end_of_input is high. Output channel (out_valid/out_ready)
// moves zero or one result per input item, in input order.
// An item is registered in the input stage at acceptance, runs through the
// phase logic from there, and its result is loaded into the output register
// when the item advances, which a stalled result can hold off.
// Throughput: one item per cycle unless a stalled result backs up, set by
// the phase update on the input register; the parse state is the only loop.
// A stalled receiver holds the result register; the input stage keeps moving
// items that give no result, and only an item that has a result waits, which
// then backs up into in_ready.
// Reset clears the parse state to the first magic byte and empties both
// stages. An end mark also returns the parser to that state.
// ---------------------------------------------------------------------------
module object_record_stream_parser_unit
	import orsp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                end_of_input,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          result_kind,
	output logic [11:0]         load_address,
	output logic [11:0]         word_value,
	output logic                stray_high_bits
);

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               eoi_s1;
	parse_state_t       state_q;
	parse_state_t       state_nxt;
	parse_result_t      res;
	logic               advance;
	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [WORD_W-1:0]  address_q;
	logic [WORD_W-1:0]  value_q;
	logic               stray_q;

	orsp_step u_step (
		.cur          (state_q),
		.data_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.nxt          (state_nxt),
		.res          (res)
	);

	// an item without a result never waits for the output register
	assign advance  = valid_s1 && (!res.valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q    <= res.kind;
			address_q <= res.address;
			value_q   <= res.value;
			stray_q   <= res.stray;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign load_address    = address_q;
	assign word_value      = value_q;
	assign stray_high_bits = stray_q;

endmodule

// ===== design/orsp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orsp_checker
// Port-level checks for the object record stream parser.
// ---------------------------------------------------------------------------
module orsp_checker
	import orsp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_ready,
	input  logic         out_valid,
	input  logic         out_ready,
	input  logic [2:0]   result_kind,
	input  logic [11:0]  load_address,
	input  logic [11:0]  word_value,
	input  logic         stray_high_bits
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind)
			&& $stable(load_address) && $stable(word_value) && $stable(stray_high_bits))
		else $error("result changed while stalled");

	// the input only backs up behind a stalled result
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input blocked without a stalled result");

	// only data words carry an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_DATA |-> load_address == '0)
		else $error("address on non-data result");

	// status results carry no word
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_DONE || result_kind == KIND_MAGIC
			|| result_kind == KIND_SHORT) |-> word_value == '0)
		else $error("word on status result");

	// magic bytes are never checked for stray bits
	a_magic_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_MAGIC |-> !stray_high_bits)
		else $error("stray flag on bad magic result");

endmodule

bind object_record_stream_parser_unit orsp_checker u_orsp_checker (.*);

// ===== tb/tb_object_record_stream_parser_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_object_record_stream_parser_unit
// Drives object streams byte by byte into the parser and checks every result
// against a cycle-free model of the phase machine. A short directed part
// covers the magic check, wrap of the load address and stray high bits.
// Random streams follow: mostly well-formed ones with random content, some
// cut short, some with a bad magic word, and some plain noise. Both sides
// idle at random.
// ---------------------------------------------------------------------------
module tb_object_record_stream_parser_unit;
	import orsp_pkg::*;

	localparam int unsigned ITEM_TARGET = 1350;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
		logic       hold;
	} stream_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] address;
		logic [11:0] value;
		logic        stray;
	} word_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  result_kind;
	logic [11:0] load_address;
	logic [11:0] word_value;
	logic        stray_high_bits;

	stream_item_t pending_items[$];
	word_result_t expected_results[$];
	logic [7:0]   stream_buf[$];
	int unsigned  items_queued = 0;
	int unsigned  error_count = 0;
	bit           drained = 1'b1;

	// predictor state
	phase_t            phase_now;
	logic signed [8:0] count_left;
	logic [11:0]       next_address;
	logic [5:0]        half_hi;
	logic              stray_pending;
	logic              magic_bad;

	object_record_stream_parser_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.end_of_input    (end_of_input),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.load_address    (load_address),
		.word_value      (word_value),
		.stray_high_bits (stray_high_bits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_parse_state();
		phase_now = PH_MAGIC0;
		count_left = '0;
		next_address = '0;
		half_hi = '0;
		stray_pending = 1'b0;
		magic_bad = 1'b0;
	endfunction

	// advances the parse state by one item; returns 1 when a result is due
	function automatic bit parse_step(input logic [7:0] b, input logic eoi,
			output word_result_t r);
		bit has_out;
		has_out = 1'b0;
		r = '0;
		if (eoi) begin
			case (phase_now)
				PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3: begin
					r.kind = KIND_MAGIC;
					has_out = 1'b1;
				end
				PH_LEN: begin
					r.kind = KIND_DONE;
					has_out = 1'b1;
				end
				PH_EP_HI, PH_EP_LO, PH_ADR_HI, PH_ADR_LO, PH_DAT_HI, PH_DAT_LO: begin
					r.kind = KIND_SHORT;
					has_out = 1'b1;
				end
				default: ;
			endcase
			r.stray = stray_pending;
			clear_parse_state();
			return has_out;
		end
		case (phase_now)
			PH_EP_HI, PH_EP_LO, PH_ADR_HI, PH_ADR_LO, PH_DAT_HI, PH_DAT_LO:
				if (b[7:6] != 2'b00)
					stray_pending = 1'b1;
			default: ;
		endcase
		case (phase_now)
			PH_MAGIC0: begin
				if (b != MAGIC_0)
					magic_bad = 1'b1;
				phase_now = PH_MAGIC1;
			end
			PH_MAGIC1: begin
				if (b != MAGIC_1)
					magic_bad = 1'b1;
				phase_now = PH_MAGIC2;
			end
			PH_MAGIC2: begin
				if (b != MAGIC_2)
					magic_bad = 1'b1;
				phase_now = PH_MAGIC3;
			end
			PH_MAGIC3: begin
				if (b != MAGIC_3 || magic_bad) begin
					phase_now = PH_WAIT;
					r.kind = KIND_MAGIC;
					has_out = 1'b1;
				end else begin
					phase_now = PH_EP_HI;
				end
			end
			PH_EP_HI: begin
				half_hi = b[5:0];
				phase_now = PH_EP_LO;
			end
			PH_EP_LO: begin
				r.kind = KIND_EP;
				r.value = {half_hi, b[5:0]};
				has_out = 1'b1;
				phase_now = PH_LEN;
			end
			PH_LEN: begin
				count_left = $signed({1'b0, b}) - 9'sd1;
				phase_now = PH_ADR_HI;
			end
			PH_ADR_HI: begin
				half_hi = b[5:0];
				phase_now = PH_ADR_LO;
			end
			PH_ADR_LO: begin
				next_address = {half_hi, b[5:0]};
				count_left = count_left - 9'sd2;
				phase_now = (count_left > 0) ? PH_DAT_HI : PH_LEN;
			end
			PH_DAT_HI: begin
				half_hi = b[5:0];
				phase_now = PH_DAT_LO;
			end
			PH_DAT_LO: begin
				r.kind = KIND_DATA;
				r.address = next_address;
				r.value = {half_hi, b[5:0]};
				has_out = 1'b1;
				next_address = next_address + 12'd1;
				count_left = count_left - 9'sd2;
				phase_now = (count_left > 0) ? PH_DAT_HI : PH_LEN;
			end
			default: ;
		endcase
		if (has_out) begin
			r.stray = stray_pending;
			stray_pending = 1'b0;
		end
		return has_out;
	endfunction

	// stream building
	task automatic buf_byte(input logic [7:0] b);
		stream_buf.push_back(b);
	endtask

	// word halves, now and then with stray high bits
	task automatic buf_word(input logic [11:0] w);
		logic [1:0] hi_bits;
		hi_bits = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
		buf_byte({hi_bits, w[11:6]});
		hi_bits = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
		buf_byte({hi_bits, w[5:0]});
	endtask

	task automatic buf_magic(input int corrupt_at);
		logic [7:0] magic[4];
		magic = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
		for (int i = 0; i < 4; i++) begin
			if (i == corrupt_at) begin
				magic[i] = magic[i] ^ 8'($urandom_range(1, 255));
			end
			buf_byte(magic[i]);
		end
	endtask

	// queues the first keep bytes of the buffer and an end mark
	task automatic flush_stream(input int unsigned keep, input int unsigned ignored,
			input bit hold);
		stream_item_t it;
		for (int unsigned i = 0; i < keep; i++) begin
			it.data = stream_buf[i];
			it.eoi = 1'b0;
			it.hold = hold && (i == 0);
			pending_items.push_back(it);
		end
		it.data = 8'($urandom_range(0, 255));
		it.eoi = 1'b1;
		it.hold = hold && (keep == 0);
		pending_items.push_back(it);
		items_queued += keep + 1 - ignored;
		stream_buf.delete();
	endtask

	task automatic build_random_stream(input bit hold);
		int unsigned choice;
		int unsigned records;
		int unsigned len;
		int unsigned junk;
		int unsigned keep;
		choice = $urandom_range(0, 99);
		if (choice < 70) begin
			buf_magic(-1);
			buf_word(12'($urandom_range(0, 4095)));
			records = $urandom_range(0, 4);
			repeat (records) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
				buf_byte(8'(len));
				if ($urandom_range(0, 3) == 0)
					buf_word(12'($urandom_range(4090, 4095)));
				else
					buf_word(12'($urandom_range(0, 4095)));
				repeat ((len > 3) ? (len - 2) / 2 : 0)
					buf_word(12'($urandom_range(0, 4095)));
			end
			// a quarter of the streams end early, possibly inside a word
			keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, stream_buf.size())
				: stream_buf.size();
			flush_stream(keep, 0, hold);
		end else if (choice < 85) begin
			buf_magic($urandom_range(0, 3));
			junk = $urandom_range(0, 5);
			repeat (junk)
				buf_byte(8'($urandom_range(0, 255)));
			flush_stream(stream_buf.size(), junk, hold);
		end else begin
			repeat ($urandom_range(0, 10)) begin
				if ($urandom_range(0, 1) == 0)
					buf_byte(8'($urandom_range(0, 255)));
				else
					buf_byte(($urandom_range(0, 1) == 0) ? MAGIC_0 : MAGIC_3);
			end
			flush_stream(stream_buf.size(), 0, hold);
		end
	endtask

	// driver: bursts of items with random gaps
	int unsigned  burst_left;
	int unsigned  gap_left;
	word_result_t predicted;
	stream_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			end_of_input <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			clear_parse_state();
		end else begin
			if (in_valid && in_ready) begin
				if (parse_step(data_byte, end_of_input, predicted))
					expected_results.push_back(predicted);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0 && !(pending_items[0].hold && !drained)) begin
					next_item = pending_items.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_item.data;
					end_of_input <= next_item.eoi;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
							: $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// sampled away from the rising edge so the hold release has no race
	always @(negedge clk)
		drained = (expected_results.size() == 0);

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
			error_count++;
		end
	endtask

	// monitor and receiver stalls
	rx_mode_t     rx_mode;
	int unsigned  rx_cycle;
	word_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode = RX_OPEN;
			rx_cycle = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, got kind %0d addr %0d value %0d",
						$time, result_kind, load_address, word_value);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", want.kind, result_kind);
					check_field("load_address", want.address, load_address);
					check_field("word_value", want.value, word_value);
					check_field("stray_high_bits", want.stray, stray_high_bits);
				end
			end
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= (rx_cycle % 8 == 0);
				default:   out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// watchdog on cycles without any handshake
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("object_record_stream_parser_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		// directed: end mark with no stream
		flush_stream(0, 0, 1'b0);
		// full-scale entry point with stray bits, empty record, address wrap
		buf_magic(-1);
		buf_byte(8'hFF);
		buf_byte(8'hFF);
		buf_byte(8'd0);
		buf_byte(8'h00);
		buf_byte(8'h00);
		buf_byte(8'd6);
		buf_byte(8'h3F);
		buf_byte(8'h3F);
		buf_byte(8'h00);
		buf_byte(8'h00);
		buf_byte(8'hC0);
		buf_byte(8'h7F);
		flush_stream(stream_buf.size(), 0, 1'b0);
		// bad second magic byte, then a byte that is ignored
		buf_byte(MAGIC_0);
		buf_byte(8'h58);
		buf_byte(MAGIC_2);
		buf_byte(MAGIC_3);
		buf_byte(MAGIC_0);
		flush_stream(stream_buf.size(), 1, 1'b0);

		// random part; the first stream waits for the directed results
		build_random_stream(1'b1);
		while (items_queued < ITEM_TARGET)
			build_random_stream($urandom_range(0, 32) == 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(pending_items.size() == 0 && !in_valid && drained))
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived, expected kind %0d next", $time,
				expected_results.size(), expected_results[0].kind);
			error_count++;
		end
		if (error_count == 0)
			$display("object_record_stream_parser_unit regression: pass");
		else
			$display("object_record_stream_parser_unit regression: fail");
		$finish;
	end

endmodule
